>>> sv/cpr_pkg.sv
// Shared widths, constants and controller/datapath interface types for the clock replacement unit.
package cpr_pkg;

    localparam int PAGE_W    = 16;
    localparam int CFG_W     = 4;
    localparam int IDX_OUT_W = 3;
    localparam int FAULT_W   = 16;

    typedef struct packed {
        logic start;        // transfer taken: latch page, rewind lookup, seed sweep
        logic scan_issue;   // read the next frame for lookup
        logic do_hit;       // record a hit on the frame just compared
        logic do_fill;      // fill the next free frame
        logic sweep_step;   // clear use bit under the hand and advance
        logic evict_read;   // read the victim frame's page
        logic evict_write;  // replace the victim and count the fault
        logic load_out;     // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic match;
        logic scan_more;
        logic table_full;
        logic use_at_hand;
        logic out_free;
    } t_status;

endpackage

>>> sv/cpr_datapath.sv
// Datapath: page memory, use bits, hand, fill count, fault counter and result registers.
module cpr_datapath import cpr_pkg::*; #(
    parameter int FRAMES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CFG_W-1:0]     i_cfg_frames,
    input  logic [PAGE_W-1:0]    i_page_number,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic                 o_replaced,
    output logic [IDX_OUT_W-1:0] o_frame_index,
    output logic [PAGE_W-1:0]    o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_count
);

    localparam int FIW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW     = $clog2(FRAMES + 1);
    localparam int SLOT_W = (FIW > IDX_OUT_W) ? FIW : IDX_OUT_W;

    logic [PAGE_W-1:0]    r_mem [FRAMES];
    logic [PAGE_W-1:0]    r_page;
    logic [CW-1:0]        r_scan_idx;
    logic                 r_rd_vld;
    logic [PAGE_W-1:0]    r_rd_data;
    logic [FIW-1:0]       r_rd_idx;
    logic [CW-1:0]        r_fill;
    logic [FIW-1:0]       r_hand;
    logic [FIW-1:0]       r_sweep;
    logic [FRAMES-1:0]    r_use;
    logic [FAULT_W-1:0]   r_faults;

    logic                 r_res_hit;
    logic                 r_res_repl;
    logic [FIW-1:0]       r_res_slot;
    logic [PAGE_W-1:0]    r_res_evict;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic                 r_out_repl;
    logic [IDX_OUT_W-1:0] r_out_slot;
    logic [PAGE_W-1:0]    r_out_evict;
    logic [FAULT_W-1:0]   r_out_faults;

    logic [CW-1:0]        managed;
    logic [CW-1:0]        limit;
    logic [CW-1:0]        sweep_inc;
    logic [FIW-1:0]       sweep_next;
    logic [FIW-1:0]       hand_start;
    logic [FIW-1:0]       fill_idx;
    logic [FIW-1:0]       rd_addr;
    logic                 wr_en;
    logic [FIW-1:0]       wr_addr;
    logic [SLOT_W-1:0]    slot_ext;

    // Clamp the configured count into 1..FRAMES
    always_comb begin
        if (i_cfg_frames == '0) begin
            managed = CW'(1);
        end else if (32'(i_cfg_frames) > FRAMES) begin
            managed = CW'(FRAMES);
        end else begin
            managed = CW'(i_cfg_frames);
        end
    end

    // Frames below the fill count are the resident ones
    assign limit      = (r_fill < managed) ? r_fill : managed;
    assign sweep_inc  = CW'(r_sweep) + CW'(1);
    assign sweep_next = (sweep_inc == managed) ? '0 : FIW'(sweep_inc);
    assign hand_start = (CW'(r_hand) >= managed) ? '0 : r_hand;
    assign fill_idx   = r_fill[FIW-1:0];
    assign rd_addr    = i_cmd.evict_read ? r_sweep : r_scan_idx[FIW-1:0];
    assign wr_en      = i_cmd.do_fill || i_cmd.evict_write;
    assign wr_addr    = i_cmd.do_fill ? fill_idx : r_sweep;
    assign slot_ext   = SLOT_W'(r_res_slot);

    assign o_status.match       = r_rd_vld && (r_rd_data == r_page);
    assign o_status.scan_more   = r_scan_idx < limit;
    assign o_status.table_full  = r_fill >= managed;
    assign o_status.use_at_hand = r_use[r_sweep];
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // Page memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_page;
        end
        if (i_cmd.scan_issue || i_cmd.evict_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page     <= i_page_number;
            r_scan_idx <= '0;
            r_sweep    <= hand_start;
        end else begin
            if (i_cmd.scan_issue) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= sweep_next;
            end
        end
        if (i_cmd.scan_issue) begin
            r_rd_idx <= r_scan_idx[FIW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_fill   <= '0;
            r_hand   <= '0;
            r_use    <= '0;
            r_faults <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.do_hit) begin
                r_use[r_rd_idx] <= 1'b1;
            end
            if (i_cmd.do_fill) begin
                r_use[fill_idx] <= 1'b1;
                r_fill          <= r_fill + CW'(1);
            end
            if (i_cmd.sweep_step) begin
                r_use[r_sweep] <= 1'b0;
            end
            if (i_cmd.evict_write) begin
                r_use[r_sweep] <= 1'b1;
                r_hand         <= sweep_next;
                if (r_faults != '1) begin
                    r_faults <= r_faults + FAULT_W'(1);
                end
            end
        end
    end

    // Result fields, held until the output register is free
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_hit) begin
            r_res_hit   <= 1'b1;
            r_res_repl  <= 1'b0;
            r_res_slot  <= r_rd_idx;
            r_res_evict <= '0;
        end else if (i_cmd.do_fill) begin
            r_res_hit   <= 1'b0;
            r_res_repl  <= 1'b0;
            r_res_slot  <= fill_idx;
            r_res_evict <= '0;
        end else if (i_cmd.evict_write) begin
            r_res_hit   <= 1'b0;
            r_res_repl  <= 1'b1;
            r_res_slot  <= r_sweep;
            r_res_evict <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit    <= r_res_hit;
            r_out_repl   <= r_res_repl;
            r_out_slot   <= slot_ext[IDX_OUT_W-1:0];
            r_out_evict  <= r_res_evict;
            r_out_faults <= r_faults;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_replaced     = r_out_repl;
    assign o_frame_index  = r_out_slot;
    assign o_evicted_page = r_out_evict;
    assign o_fault_count  = r_out_faults;

endmodule

>>> sv/cpr_ctrl.sv
// Controller state machine: lookup, fill, hand sweep, eviction and result hand-off.
module cpr_ctrl import cpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.match) begin
                    o_cmd.do_hit = 1'b1;
                    n_state      = S_DONE;
                end else if (i_status.scan_more) begin
                    o_cmd.scan_issue = 1'b1;
                end else if (i_status.table_full) begin
                    n_state = S_SWEEP;
                end else begin
                    o_cmd.do_fill = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SWEEP: begin
                // give set frames a second chance, stop at the first clear bit
                if (i_status.use_at_hand) begin
                    o_cmd.sweep_step = 1'b1;
                end else begin
                    o_cmd.evict_read = 1'b1;
                    n_state          = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict_write = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> sv/clock_page_replacement_unit.sv
// Top level: configuration port, controller and datapath of the clock replacement unit.
//
// Clock (second-chance) page replacement over up to FRAMES frames; frames_in_use
// (byte address 0) picks how many are managed. Each transferred page reference
// yields one result. Frames are looked up one per cycle through the page
// memory's single read port. A hit ends the lookup at the matching frame; a
// miss fills a free frame once all resident managed frames are compared; a
// fault makes the hand clear the s (0..n, n the managed count) set use bits
// it passes, then reads and replaces the first frame with a clear bit. A new
// reference is taken as soon as the previous one is finished, even while its
// result still waits in the output register.
module clock_page_replacement_unit import cpr_pkg::*; #(
    parameter int FRAMES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PAGE_W-1:0]    i_page_number,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic                 o_replaced,
    output logic [IDX_OUT_W-1:0] o_frame_index,
    output logic [PAGE_W-1:0]    o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_count
);

    localparam logic REG_FRAMES_IN_USE = 1'b0;

    logic [CFG_W-1:0] r_cfg_frames;
    logic             cfg_wr;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frames <= CFG_W'(8);
        end else if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
            r_cfg_frames <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FRAMES_IN_USE) begin
            prdata = {{(32-CFG_W){1'b0}}, r_cfg_frames};
        end
    end

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cpr_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_frames   (r_cfg_frames),
        .i_page_number  (i_page_number),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_hit          (o_hit),
        .o_replaced     (o_replaced),
        .o_frame_index  (o_frame_index),
        .o_evicted_page (o_evicted_page),
        .o_fault_count  (o_fault_count)
    );

    a_hit_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_replaced))
        else $error("result flags both hit and replacement");

    a_evict_only_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_replaced) |-> (o_evicted_page == '0))
        else $error("evicted page reported without a replacement");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_replaced) |-> (o_fault_count != '0))
        else $error("replacement reported with zero fault count");

    a_one_load_per_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> !cmd.load_out)
        else $error("two results loaded back to back");

endmodule
